### hdl/grant_free_slot_harq_tracker_defines.svh
// Assertion macros shared by the grant-free slot and HARQ tracker RTL.
`ifndef GRANT_FREE_SLOT_HARQ_TRACKER_DEFINES_SVH
`define GRANT_FREE_SLOT_HARQ_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, quiet while reset is asserted.
`define GFSHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked property, also evaluated during reset.
`define GFSHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GFSHT_ASSERT(lbl, prop, msg)
`define GFSHT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hdl/gfsht_pkg.sv
// Widths, codes and shared types of the grant-free slot and HARQ tracker.
package gfsht_pkg;

  localparam int ABS_W              = 18;
  localparam int PERIOD_W           = 8;
  localparam int FRAME_W            = 10;
  localparam int SLOT_W             = 8;
  localparam int CMD_W              = 2;
  localparam int NUMER_W            = 3;
  localparam int ROUND_W            = 4;
  localparam int PROC_OUT_W         = 3;
  localparam int CNT_W              = 32;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 8;
  localparam int HARQ_PROCESSES_DEF = 8;

  localparam logic [NUMER_W-1:0] MAX_NUMER = 3'd4;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SCHED_READY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TX_ENABLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUMEROLOGY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SLOTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROUNDS   = 3'd4;

  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 8'd1;
  localparam logic [ROUND_W-1:0]  MAX_ROUNDS_RST = 4'd4;

  typedef struct packed {
    logic               apply;
    logic [CMD_W-1:0]   cmd;
    logic               crc_good;
    logic               opp;
    logic               sched_ready;
    logic [ROUND_W-1:0] max_rounds;
  } harq_ctrl_t;

  typedef struct packed {
    logic [ROUND_W-1:0] round;
    logic               discard;
    logic [CNT_W-1:0]   opp_cnt;
    logic [CNT_W-1:0]   succ_cnt;
    logic [CNT_W-1:0]   fail_cnt;
  } harq_stat_t;

endpackage

### hdl/gfsht_mod_unit.sv
// Bit-serial remainder unit: absolute slot modulo the opportunity period.
module gfsht_mod_unit import gfsht_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [ABS_W-1:0]    dividend_i,
  input  logic [PERIOD_W-1:0] divisor_i,
  output logic                done_o,
  output logic                rem_zero_o
);

  localparam int CNT_BITS = $clog2(ABS_W + 1);

  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [PERIOD_W-1:0] div_q;
  logic [ABS_W-1:0]    shreg_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [PERIOD_W:0]   trial;

  // Shift one dividend bit into the partial remainder, subtract if it fits.
  always_comb begin
    trial = {rem_q, shreg_q[ABS_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = PERIOD_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(ABS_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= '0;
      div_q   <= divisor_i;
      shreg_q <= dividend_i;
    end else if (busy_q) begin
      rem_q   <= rem_d;
      shreg_q <= shreg_q << 1;
    end
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

### hdl/gfsht_harq.sv
// HARQ process and round state with the wrapping statistics counters.
module gfsht_harq import gfsht_pkg::*; #(
  parameter int HARQ_PROCESSES = HARQ_PROCESSES_DEF,
  localparam int PROC_W = $clog2(HARQ_PROCESSES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  harq_ctrl_t        ctrl_i,
  output logic [PROC_W-1:0] proc_next_o,
  output harq_stat_t        stat_next_o
);

  logic [PROC_W-1:0]  proc_q, proc_d, proc_inc;
  logic [ROUND_W-1:0] round_q, round_d;
  logic [CNT_W-1:0]   opp_q, opp_d, succ_q, succ_d, fail_q, fail_d;
  logic [ROUND_W:0]   round_next;
  logic               discard;

  assign proc_inc   = (proc_q == PROC_W'(HARQ_PROCESSES - 1)) ? '0 : proc_q + 1'b1;
  assign round_next = {1'b0, round_q} + 1'b1;

  always_comb begin
    proc_d  = proc_q;
    round_d = round_q;
    opp_d   = opp_q;
    succ_d  = succ_q;
    fail_d  = fail_q;
    discard = 1'b0;
    case (ctrl_i.cmd)
      CMD_TICK: begin
        if (ctrl_i.opp) begin
          opp_d = opp_q + 1'b1;
        end
      end
      CMD_PUSCH: begin
        if (ctrl_i.sched_ready) begin
          if (ctrl_i.crc_good) begin
            succ_d  = succ_q + 1'b1;
            proc_d  = proc_inc;
            round_d = '0;
          end else begin
            fail_d = fail_q + 1'b1;
            // drop the block once the round count reaches the limit
            if (round_next >= {1'b0, ctrl_i.max_rounds}) begin
              discard = 1'b1;
              proc_d  = proc_inc;
              round_d = '0;
            end else begin
              round_d = round_next[ROUND_W-1:0];
            end
          end
        end
      end
      CMD_CLEAR: begin
        proc_d  = '0;
        round_d = '0;
        opp_d   = '0;
        succ_d  = '0;
        fail_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_q  <= '0;
      round_q <= '0;
      opp_q   <= '0;
      succ_q  <= '0;
      fail_q  <= '0;
    end else if (ctrl_i.apply) begin
      proc_q  <= proc_d;
      round_q <= round_d;
      opp_q   <= opp_d;
      succ_q  <= succ_d;
      fail_q  <= fail_d;
    end
  end

  assign proc_next_o          = proc_d;
  assign stat_next_o.round    = round_d;
  assign stat_next_o.discard  = discard;
  assign stat_next_o.opp_cnt  = opp_d;
  assign stat_next_o.succ_cnt = succ_d;
  assign stat_next_o.fail_cnt = fail_d;

endmodule

### hdl/grant_free_slot_harq_tracker.sv
// Grant-free uplink slot and HARQ tracker for one UE.
// Input channel (in_valid_i/in_ready_o) carries one command per transfer: a slot
// tick with frame and slot number, a PUSCH decode result with its CRC flag, or
// a clear of the statistics and HARQ state. Output channel (out_valid_o /
// out_ready_i) returns one result per command: opportunity flag, HARQ process
// and round, discard flag and the three wrapping 32-bit counters after it.
// An eligible slot tick (ready, enabled, nonzero period) runs the absolute slot
// through an 18-step bit-serial remainder unit, then waits in the commit state
// for the output register. Every other command goes straight from acceptance
// to the commit state. The sequencer takes the next command the cycle after the
// result register loads: one command in flight, ready only when it is idle.
// The result sits in an output register; a new command is accepted while it
// waits, but the sequencer holds the next result until the receiver takes the
// pending one, so a stalled receiver stalls the input after one command.
// Configuration is a plain write port (sched_ready, tx_enable, numerology, period_slots,
// max_rounds); the user must write it only while the block is idle, as the block does not enforce this.
// Reset clears the counters, HARQ state and configuration to defaults.
`include "grant_free_slot_harq_tracker_defines.svh"

module grant_free_slot_harq_tracker import gfsht_pkg::*; #(
  parameter int HARQ_PROCESSES = HARQ_PROCESSES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [FRAME_W-1:0]    frame_num_i,
  input  logic [SLOT_W-1:0]     slot_num_i,
  input  logic                  crc_good_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  tx_opportunity_o,
  output logic [PROC_OUT_W-1:0] harq_process_o,
  output logic [ROUND_W-1:0]    harq_round_o,
  output logic                  block_discarded_o,
  output logic [CNT_W-1:0]      opportunity_count_o,
  output logic [CNT_W-1:0]      success_count_o,
  output logic [CNT_W-1:0]      error_count_o
);

  localparam int PROC_W = $clog2(HARQ_PROCESSES);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIV    = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic                sched_ready_q, tx_enable_q;
  logic [NUMER_W-1:0]  numer_q;
  logic [PERIOD_W-1:0] period_q;
  logic [ROUND_W-1:0]  max_rounds_q;

  logic [CMD_W-1:0]    cmd_q;
  logic                crc_q;
  logic                opp_q;

  logic                in_xfer, eligible, mod_start, mod_done, mod_zero, commit;
  logic [NUMER_W-1:0]  mu;
  logic [ABS_W-1:0]    frame_x10, frame_slot;

  harq_ctrl_t          harq_ctrl;
  harq_stat_t          stat_next, stat_out_q;
  logic [PROC_W-1:0]   proc_next, proc_out_q;
  logic                out_valid_q, opp_out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_ready_q <= 1'b0;
      tx_enable_q   <= 1'b0;
      numer_q       <= '0;
      period_q      <= PERIOD_RST;
      max_rounds_q  <= MAX_ROUNDS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCHED_READY:  sched_ready_q <= cfg_data_i[0];
        REG_TX_ENABLE:    tx_enable_q   <= cfg_data_i[0];
        REG_NUMEROLOGY:   numer_q       <= cfg_data_i[NUMER_W-1:0];
        REG_PERIOD_SLOTS: period_q      <= cfg_data_i[PERIOD_W-1:0];
        REG_MAX_ROUNDS:   max_rounds_q  <= cfg_data_i[ROUND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign eligible   = (cmd_i == CMD_TICK) && sched_ready_q && tx_enable_q &&
                      (period_q != '0);
  assign mod_start  = in_xfer && eligible;

  // absolute slot = frame * (10 << mu) + slot, with mu clamped to four
  assign mu         = (numer_q > MAX_NUMER) ? MAX_NUMER : numer_q;
  assign frame_x10  = (ABS_W'(frame_num_i) << 3) + (ABS_W'(frame_num_i) << 1);
  assign frame_slot = (frame_x10 << mu) + ABS_W'(slot_num_i);

  gfsht_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (frame_slot),
    .divisor_i  (period_q),
    .done_o     (mod_done),
    .rem_zero_o (mod_zero)
  );

  // hold the result until the output register is free
  assign commit = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = eligible ? ST_DIV : ST_COMMIT;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= cmd_i;
      crc_q <= crc_good_i;
      opp_q <= 1'b0;
    end else if ((state_q == ST_DIV) && mod_done) begin
      opp_q <= mod_zero;
    end
  end

  assign harq_ctrl.apply       = commit;
  assign harq_ctrl.cmd         = cmd_q;
  assign harq_ctrl.crc_good    = crc_q;
  assign harq_ctrl.opp         = opp_q;
  assign harq_ctrl.sched_ready = sched_ready_q;
  assign harq_ctrl.max_rounds  = max_rounds_q;

  gfsht_harq #(
    .HARQ_PROCESSES (HARQ_PROCESSES)
  ) u_harq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (harq_ctrl),
    .proc_next_o (proc_next),
    .stat_next_o (stat_next)
  );

  always_ff @(posedge clk_i) begin
    if (commit) begin
      opp_out_q  <= opp_q;
      proc_out_q <= proc_next;
      stat_out_q <= stat_next;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign tx_opportunity_o    = opp_out_q;
  assign harq_process_o      = PROC_OUT_W'(proc_out_q);
  assign harq_round_o        = stat_out_q.round;
  assign block_discarded_o   = stat_out_q.discard;
  assign opportunity_count_o = stat_out_q.opp_cnt;
  assign success_count_o     = stat_out_q.succ_cnt;
  assign error_count_o       = stat_out_q.fail_cnt;

  `GFSHT_ASSERT(a_one_in_flight, in_xfer |=> !in_ready_o, "second command accepted while busy")
  `GFSHT_ASSERT(a_div_to_commit, (state_q == ST_DIV) && mod_done |=> (state_q == ST_COMMIT),
                "remainder done did not move to commit")
  `GFSHT_ASSERT(a_discard_round, out_valid_o && block_discarded_o |-> (harq_round_o == '0),
                "discarded block left a nonzero round")
  `GFSHT_ASSERT_ALWAYS(a_opp_xor_discard, out_valid_o |-> !(tx_opportunity_o && block_discarded_o),
                       "opportunity and discard flagged on the same result")

endmodule
